// File: design/utp_pkg.sv
// Shared types and constants for the UUID text parser.
`timescale 1ns / 1ps
package utp_pkg;

  // Classified character handed from the front to the back.
  typedef struct packed {
    logic [3:0] nibble;
    logic       is_hex;
    logic       is_dash;
    logic       last;
  } entry_t;

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  localparam logic [5:0] POS_DASH0    = 6'd8;
  localparam logic [5:0] POS_DASH1    = 6'd13;
  localparam logic [5:0] POS_DASH2    = 6'd18;
  localparam logic [5:0] POS_DASH3    = 6'd23;
  localparam logic [5:0] BARE_LEN     = 6'd32;
  localparam logic [5:0] HYPHEN_LEN   = 6'd36;
  localparam logic [5:0] BARE_NODE    = 6'd20;
  localparam logic [5:0] HYPHEN_NODE  = 6'd23;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_SEPARATORS = 3'd2;
  localparam logic [2:0] ST_FIELD_HEX  = 3'd3;
  localparam logic [2:0] ST_NODE_HEX   = 3'd4;

endpackage

// File: design/utp_front.sv
// Front end: classify one character into a hex nibble and flags.
`timescale 1ns / 1ps
module utp_front (
  input  logic [7:0]      char_code,
  input  logic            last_char,
  output utp_pkg::entry_t entry
);
  import utp_pkg::*;

  logic [3:0] nib;
  logic       hex;

  always_comb begin
    nib = 4'd0;
    hex = 1'b1;
    if (char_code >= 8'h61 && char_code <= 8'h66) begin
      nib = 4'(char_code - 8'h57);
    end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
      nib = 4'(char_code - 8'h37);
    end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
      nib = char_code[3:0];
    end else begin
      hex = 1'b0;
    end
  end

  assign entry.nibble  = nib;
  assign entry.is_hex  = hex;
  assign entry.is_dash = (char_code == DASH_CHAR);
  assign entry.last    = last_char;

endmodule

// File: design/utp_queue.sv
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps
module utp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  utp_pkg::entry_t wr_data,
  input  logic            rd_en,
  output utp_pkg::entry_t rd_data,
  output logic            full,
  output logic            valid
);
  import utp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);

endmodule

// File: design/utp_back.sv
// Back end: position tracking, both digit readings, status and result register.
`timescale 1ns / 1ps
module utp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  utp_pkg::entry_t in_entry,
  output logic            in_take,
  input  logic            pop,
  output logic            empty,
  output logic [31:0]     time_low_field,
  output logic [15:0]     time_mid_field,
  output logic [15:0]     time_high_version_field,
  output logic [15:0]     clock_sequence_field,
  output logic [47:0]     node_field,
  output logic [2:0]      status
);
  import utp_pkg::*;

  logic [5:0]   pos;
  logic         hmode;
  logic [127:0] bare_acc;
  logic [2:0]   bare_err;
  logic [127:0] hyp_acc;
  logic [2:0]   hyp_err;

  logic [5:0]   pos_next;
  logic         hmode_next;
  logic [127:0] bare_acc_next;
  logic [2:0]   bare_err_next;
  logic [127:0] hyp_acc_next;
  logic [2:0]   hyp_err_next;
  logic [2:0]   st;
  logic [127:0] src;

  logic out_valid;
  logic out_free;

  assign out_free = !out_valid || pop;
  assign in_take  = in_valid && (!in_entry.last || out_free);

  always_comb begin
    pos_next      = pos;
    hmode_next    = hmode;
    bare_acc_next = bare_acc;
    bare_err_next = bare_err;
    hyp_acc_next  = hyp_acc;
    hyp_err_next  = hyp_err;
    if (pos < BARE_LEN) begin
      bare_acc_next = {bare_acc[123:0], in_entry.nibble};
      if (!in_entry.is_hex && bare_err == ST_OK) begin
        bare_err_next = (pos < BARE_NODE) ? ST_FIELD_HEX : ST_NODE_HEX;
      end
    end
    if (pos < HYPHEN_LEN) begin
      if (pos == POS_DASH0) begin
        hmode_next = in_entry.is_dash;
      end else if (pos == POS_DASH1 || pos == POS_DASH2 || pos == POS_DASH3) begin
        if (!in_entry.is_dash) hmode_next = 1'b0;
      end else begin
        hyp_acc_next = {hyp_acc[123:0], in_entry.nibble};
        if (!in_entry.is_hex && hyp_err == ST_OK) begin
          hyp_err_next = (pos < HYPHEN_NODE) ? ST_FIELD_HEX : ST_NODE_HEX;
        end
      end
      pos_next = pos + 6'd1;
    end

    // Length counts this character, so compare the old position one lower.
    src = bare_acc_next;
    if (pos < BARE_LEN - 6'd1) begin
      st = ST_SHORT;
    end else if (hmode_next) begin
      if (pos < HYPHEN_LEN - 6'd1) begin
        st = ST_SEPARATORS;
      end else begin
        st  = hyp_err_next;
        src = hyp_acc_next;
      end
    end else begin
      st = bare_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      hmode     <= 1'b0;
      bare_acc  <= '0;
      bare_err  <= ST_OK;
      hyp_acc   <= '0;
      hyp_err   <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (in_take && in_entry.last) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        if (in_entry.last) begin
          // Return to the start state for the next string.
          pos       <= '0;
          hmode     <= 1'b0;
          bare_acc  <= '0;
          bare_err  <= ST_OK;
          hyp_acc   <= '0;
          hyp_err   <= ST_OK;
        end else begin
          pos      <= pos_next;
          hmode    <= hmode_next;
          bare_acc <= bare_acc_next;
          bare_err <= bare_err_next;
          hyp_acc  <= hyp_acc_next;
          hyp_err  <= hyp_err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_entry.last) begin
      status <= st;
      if (st == ST_OK) begin
        time_low_field          <= src[127:96];
        time_mid_field          <= src[95:80];
        time_high_version_field <= src[79:64];
        clock_sequence_field    <= src[63:48];
        node_field              <= src[47:0];
      end else begin
        time_low_field          <= '0;
        time_mid_field          <= '0;
        time_high_version_field <= '0;
        clock_sequence_field    <= '0;
        node_field              <= '0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

// File: design/uuid_text_parser.sv
// Top level of the streaming UUID text parser.
// Takes one character per cycle as an item on the push side while not full, and gives one result
// item (five UUID fields and a status) after the character flagged last_char. Sustained rate
// is one character per clock; it is set by the back-end parser, which consumes one queued
// character per cycle, except that it holds a last character while an earlier result still
// waits unpopped. A result is registered when the parser takes its last character and waits
// in the output register until popped; meanwhile characters of the next string keep flowing
// into the queue (QUEUE_DEPTH entries) and through the parser.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
module uuid_text_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] time_low_field,
  output logic [15:0] time_mid_field,
  output logic [15:0] time_high_version_field,
  output logic [15:0] clock_sequence_field,
  output logic [47:0] node_field,
  output logic [2:0]  status
);
  import utp_pkg::*;

  entry_t front_entry;
  entry_t queue_entry;
  logic   queue_valid;
  logic   back_take;

  utp_front u_front (
    .char_code (char_code),
    .last_char (last_char),
    .entry     (front_entry)
  );

  utp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_entry),
    .rd_en   (back_take),
    .rd_data (queue_entry),
    .full    (full),
    .valid   (queue_valid)
  );

  utp_back u_back (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (queue_valid),
    .in_entry                (queue_entry),
    .in_take                 (back_take),
    .pop                     (pop),
    .empty                   (empty),
    .time_low_field          (time_low_field),
    .time_mid_field          (time_mid_field),
    .time_high_version_field (time_high_version_field),
    .clock_sequence_field    (clock_sequence_field),
    .node_field              (node_field),
    .status                  (status)
  );

endmodule

// File: design/utp_checker.sv
// Port-level assertions for the UUID text parser, bound to the top level.
`timescale 1ns / 1ps
module utp_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [31:0] time_low_field,
  input logic [15:0] time_mid_field,
  input logic [15:0] time_high_version_field,
  input logic [15:0] clock_sequence_field,
  input logic [47:0] node_field,
  input logic [2:0]  status
);
  import utp_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_OK || status == ST_SHORT || status == ST_SEPARATORS ||
                status == ST_FIELD_HEX || status == ST_NODE_HEX))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (time_low_field == '0 && time_mid_field == '0 &&
      time_high_version_field == '0 && clock_sequence_field == '0 && node_field == '0))
    else $error("failed parse carries nonzero fields");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(node_field) &&
                          $stable(time_low_field)))
    else $error("stalled result item changed");

endmodule

bind uuid_text_parser utp_checker u_utp_checker (
  .clk                     (clk),
  .rst                     (rst),
  .full                    (full),
  .pop                     (pop),
  .empty                   (empty),
  .time_low_field          (time_low_field),
  .time_mid_field          (time_mid_field),
  .time_high_version_field (time_high_version_field),
  .clock_sequence_field    (clock_sequence_field),
  .node_field              (node_field),
  .status                  (status)
);

// File: test/uuid_text_checker.sv
// Watches the parser's character and result items, predicts each result and compares.
`timescale 1ns / 1ps
module uuid_text_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        pop,
  input  logic        empty,
  input  logic [31:0] time_low_field,
  input  logic [15:0] time_mid_field,
  input  logic [15:0] time_high_version_field,
  input  logic [15:0] clock_sequence_field,
  input  logic [47:0] node_field,
  input  logic [2:0]  status,
  output int          fail_count,
  output int          pending
);
  import utp_pkg::*;

  typedef struct packed {
    logic [31:0] low_word;
    logic [15:0] mid_word;
    logic [15:0] time_hi;
    logic [15:0] clk_seq;
    logic [47:0] node;
    logic [2:0]  status;
  } uuid_fields_t;

  uuid_fields_t uuid_expected[$];

  logic [5:0]   char_pos;
  logic         dash_form;
  logic [127:0] bare_acc;
  logic [127:0] dash_acc;
  logic [2:0]   bare_err;
  logic [2:0]   dash_err;

  // Bit 4 set means the character is not a hex digit; low nibble is then zero.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    return 5'h10;
  endfunction

  task automatic clear_parse();
    char_pos  = '0;
    dash_form = 1'b0;
    bare_acc  = '0;
    dash_acc  = '0;
    bare_err  = ST_OK;
    dash_err  = ST_OK;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic [4:0]   nib;
    logic [5:0]   len;
    logic [2:0]   st;
    logic [127:0] src;
    uuid_fields_t r;
    nib = hex_nibble(c);
    len = char_pos + 6'd1;
    if (char_pos < BARE_LEN) begin
      bare_acc = {bare_acc[123:0], nib[3:0]};
      if (nib[4] && bare_err == ST_OK)
        bare_err = (char_pos < BARE_NODE) ? ST_FIELD_HEX : ST_NODE_HEX;
    end
    if (char_pos < HYPHEN_LEN) begin
      if (char_pos == POS_DASH0) begin
        dash_form = (c == DASH_CHAR);
      end else if (char_pos == POS_DASH1 || char_pos == POS_DASH2 || char_pos == POS_DASH3) begin
        if (c != DASH_CHAR) dash_form = 1'b0;
      end else begin
        dash_acc = {dash_acc[123:0], nib[3:0]};
        if (nib[4] && dash_err == ST_OK)
          dash_err = (char_pos < HYPHEN_NODE) ? ST_FIELD_HEX : ST_NODE_HEX;
      end
      char_pos = char_pos + 6'd1;
    end
    if (fin) begin
      src = bare_acc;
      if (len < BARE_LEN) begin
        st = ST_SHORT;
      end else if (dash_form) begin
        if (len < HYPHEN_LEN) begin
          st = ST_SEPARATORS;
        end else begin
          st  = dash_err;
          src = dash_acc;
        end
      end else begin
        st = bare_err;
      end
      r = '0;
      if (st == ST_OK) begin
        r.low_word = src[127:96];
        r.mid_word = src[95:80];
        r.time_hi  = src[79:64];
        r.clk_seq  = src[63:48];
        r.node     = src[47:0];
      end
      r.status = st;
      uuid_expected.push_back(r);
      clear_parse();
    end
  endtask

  task automatic report_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_parse();
  end

  always @(posedge clk) begin
    uuid_fields_t w;
    if (rst) begin
      clear_parse();
      uuid_expected.delete();
    end else begin
      if (pop && !empty) begin
        if (uuid_expected.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none expected, status actual %0d", $time, status);
        end else begin
          w = uuid_expected.pop_front();
          report_field("time_low_field", 48'(w.low_word), 48'(time_low_field));
          report_field("time_mid_field", 48'(w.mid_word), 48'(time_mid_field));
          report_field("time_high_version_field", 48'(w.time_hi),
                       48'(time_high_version_field));
          report_field("clock_sequence_field", 48'(w.clk_seq), 48'(clock_sequence_field));
          report_field("node_field", w.node, node_field);
          report_field("status", 48'(w.status), 48'(status));
        end
      end
      if (push && !full) parse_char(char_code, last_char);
    end
    pending = uuid_expected.size();
  end

endmodule

// File: test/tb_uuid_text_parser.sv
// Stimulus and verdict for the UUID text parser, checked by uuid_text_checker.
`timescale 1ns / 1ps
module tb_uuid_text_parser;
  import utp_pkg::*;

  localparam int CHAR_TARGET = 1000;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  char_code;
  logic        last_char;
  logic        pop = 1'b0;
  logic        empty;
  logic [31:0] time_low_field;
  logic [15:0] time_mid_field;
  logic [15:0] time_high_version_field;
  logic [15:0] clock_sequence_field;
  logic [47:0] node_field;
  logic [2:0]  status;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          quiet = 1'b0;
  byte unsigned text[$];

  uuid_text_parser uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_code(char_code),
    .last_char(last_char), .pop(pop), .empty(empty), .time_low_field(time_low_field),
    .time_mid_field(time_mid_field), .time_high_version_field(time_high_version_field),
    .clock_sequence_field(clock_sequence_field), .node_field(node_field), .status(status)
  );

  uuid_text_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_code(char_code),
    .last_char(last_char), .pop(pop), .empty(empty), .time_low_field(time_low_field),
    .time_mid_field(time_mid_field), .time_high_version_field(time_high_version_field),
    .clock_sequence_field(clock_sequence_field), .node_field(node_field), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side at random, except during the quiet stretch.
  always @(negedge clk) begin
    pop <= !rst && (quiet || $urandom_range(0, 99) >= 26);
  end

  function automatic byte unsigned hex_char(input int v, input int case_mode);
    bit upper;
    upper = (case_mode == 2) ? 1'($urandom_range(0, 1)) : (case_mode == 1);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic bit dash_slot(input int i);
    return i == POS_DASH0 || i == POS_DASH1 || i == POS_DASH2 || i == POS_DASH3;
  endfunction

  task automatic make_uuid(input bit dashed, input int case_mode);
    text = {};
    for (int i = 0; i < (dashed ? HYPHEN_LEN : BARE_LEN); i++) begin
      if (dashed && dash_slot(i)) text.push_back(DASH_CHAR);
      else text.push_back(hex_char($urandom_range(0, 15), case_mode));
    end
  endtask

  task automatic fill_uuid(input bit dashed, input byte unsigned c);
    text = {};
    for (int i = 0; i < (dashed ? HYPHEN_LEN : BARE_LEN); i++)
      text.push_back((dashed && dash_slot(i)) ? DASH_CHAR : c);
  endtask

  task automatic put_char(input byte unsigned c, input bit fin);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 26) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push      <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text[i]) put_char(text[i], i == text.size() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int kind;
    int strings;
    int dash_pos[4];
    rst       = 1'b1;
    push      = 1'b0;
    char_code = '0;
    last_char = 1'b0;
    dash_pos  = '{POS_DASH0, POS_DASH1, POS_DASH2, POS_DASH3};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: digit extremes, both forms, case mixes.
    fill_uuid(1'b1, 8'h30); send_text();
    fill_uuid(1'b1, 8'h66); send_text();
    fill_uuid(1'b0, 8'h46); send_text();
    fill_uuid(1'b0, 8'h39); send_text();
    make_uuid(1'b1, 0); send_text();
    make_uuid(1'b1, 1); send_text();
    make_uuid(1'b0, 2); send_text();
    // Too short: one character, then 31.
    text = {8'h61}; send_text();
    make_uuid(1'b0, 2); text = text[0:30]; send_text();
    // All hyphens present but the string ends early.
    make_uuid(1'b1, 2); text = text[0:34]; send_text();
    make_uuid(1'b1, 2); text = text[0:31]; send_text();
    // A later hyphen missing: falls back to the bare reading.
    make_uuid(1'b1, 0); text[POS_DASH1] = 8'h61; send_text();
    make_uuid(1'b1, 1); text[POS_DASH3] = 8'h30; send_text();
    // Bad hex at the field/node boundary of each reading, and at other positions.
    make_uuid(1'b0, 0); text[19] = 8'h67; send_text();
    make_uuid(1'b0, 1); text[20] = 8'h47; send_text();
    make_uuid(1'b1, 0); text[22] = 8'h2F; send_text();
    make_uuid(1'b1, 1); text[24] = 8'h3A; send_text();
    make_uuid(1'b1, 2); text[35] = 8'h40; send_text();
    make_uuid(1'b0, 2); text[5] = 8'h60; text[25] = 8'hFF; send_text();
    make_uuid(1'b0, 2); text[0] = 8'h00; send_text();
    // Characters past the needed length.
    make_uuid(1'b1, 1); repeat (5) text.push_back(DASH_CHAR); send_text();
    make_uuid(1'b0, 0); repeat (4) text.push_back(8'h7A); send_text();
    make_uuid(1'b1, 2); repeat (28) text.push_back(8'($urandom_range(0, 255))); send_text();
    drain();

    sent    = 0;
    strings = 0;
    while (sent < CHAR_TARGET) begin
      quiet = (strings >= 12 && strings < 24);
      kind  = $urandom_range(0, 99);
      if (kind < 40) begin
        make_uuid(1'b1, $urandom_range(0, 2));
      end else if (kind < 62) begin
        make_uuid(1'b0, $urandom_range(0, 2));
      end else if (kind < 72) begin
        make_uuid(1'($urandom_range(0, 1)), $urandom_range(0, 2));
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 80) begin
        make_uuid(1'($urandom_range(0, 1)), $urandom_range(0, 2));
        text = text[0:$urandom_range(0, text.size() - 2)];
      end else if (kind < 88) begin
        make_uuid(1'($urandom_range(0, 1)), $urandom_range(0, 2));
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        make_uuid(1'b1, $urandom_range(0, 2));
        text[dash_pos[$urandom_range(0, 3)]] = hex_char($urandom_range(0, 15), 2);
      end else begin
        text = {};
        repeat ($urandom_range(1, 45)) text.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
      sent += text.size();
      strings++;
      // After every 20th string, hold off the next string until every result is out.
      if (strings % 20 == 0) drain();
    end
    quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
